// File: rtl/ric_pkg.sv
// ----------------------------------------------------------------------------
// ric_pkg: shared types and constants of the inode cache table
// Table geometry, request and status codes, and the packed layouts of the
// stream payloads and of one stored table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package ric_pkg;

   // Table geometry
   localparam int NUM_SLOTS = 64;
   localparam int REF_BITS  = 16;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // Request codes carried on tuser
   typedef enum logic [1:0] {
      REQ_ACQUIRE = 2'd0,
      REQ_RELEASE = 2'd1,
      REQ_MARK    = 2'd2,
      REQ_NONE    = 2'd3
   } req_code_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_FREE_REL = 2'd2,
      ST_OVF      = 2'd3
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_SLOT = 2'd2
   } state_type;

   // Request payload, last field in the lowest bits
   typedef struct packed {
      logic [1:0]  pad;
      logic [5:0]  slot_in;
      logic [31:0] inode_number;
      logic [7:0]  device_id;
   } req_data_type;

   // Result payload, last field in the lowest bits
   typedef struct packed {
      logic [5:0]  pad;
      logic [15:0] ref_now;
      logic        needs_writeback;
      logic        load_needed;
      status_type  status;
      logic [5:0]  slot_out;
   } rsp_data_type;

   // One stored table entry
   typedef struct packed {
      logic [REF_BITS-1:0] refs;
      logic [7:0]          device;
      logic [31:0]         inode;
      logic                dirty;
   } entry_type;

endpackage

`default_nettype wire

// File: rtl/refcounted_inode_cache_table.sv
// Operation: one request at a time. An acquire walks the entry RAM one slot a
//   cycle until a hit or the last slot; release, mark and the unused code
//   read only the addressed slot.
// Reset: the held bit of every slot clears at once, so the table is empty in
//   the first cycle after reset; no clearing pass runs over the RAM.
// ----------------------------------------------------------------------------
// refcounted_inode_cache_table: reference counted inode slot table
// Acquire finds or claims a slot by device and inode number, release drops
// a reference and frees the slot at zero, mark sets the dirty flag.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_inode_cache_table (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // [7:0] device_id, [39:8] inode_number, [45:40] slot_in, [47:46] zero
   input  wire ric_pkg::req_data_type req_tdata,
   // [1:0] req_type
   input  wire logic [1:0]            req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [5:0] slot_out, [7:6] status, [8] load_needed, [9] needs_writeback,
   // [25:10] ref_now, [31:26] zero
   output      ric_pkg::rsp_data_type rsp_tdata
);

   import ric_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   // Sequencer and scan registers
   state_type             state_ff, state_in;
   logic [NUM_SLOTS-1:0]  held_ff, held_in;
   logic [SLOT_W-1:0]     issue_idx_ff, issue_idx_in;
   logic                  issue_live_ff, issue_live_in;
   logic [SLOT_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                  cmp_live_ff, cmp_live_in;
   logic                  free_found_ff, free_found_in;
   logic [SLOT_W-1:0]     free_idx_ff, free_idx_in;

   // Captured request
   req_code_type          op_ff, op_in;
   logic [7:0]            dev_ff, dev_in;
   logic [31:0]           ino_ff, ino_in;
   logic [5:0]            slot_ff, slot_in_q;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_data_type          rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                  ram_wr_en;
   logic [SLOT_W-1:0]     ram_wr_addr;
   entry_type             ram_wr_data;
   logic                  ram_rd_en;
   logic [SLOT_W-1:0]     ram_rd_addr;
   logic [$bits(entry_type)-1:0] ram_rd_raw;
   entry_type             rd_entry;

   // Comparison helpers
   logic                  req_fire;
   logic                  hit;
   logic                  free_here;
   logic                  slot_ok;
   logic [SLOT_W-1:0]     slot_idx;
   logic                  slot_held;
   logic [SLOT_W-1:0]     claim_idx;
   logic [REF_BITS-1:0]   dec_refs;

   assign rd_entry   = entry_type'(ram_rd_raw);
   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Slot addressed by release or mark
   assign slot_ok   = 32'(slot_ff) < NUM_SLOTS;
   assign slot_idx  = SLOT_W'(slot_ff);
   assign slot_held = slot_ok && held_ff[slot_idx];
   assign dec_refs  = rd_entry.refs - REF_BITS'(1);

   // Scan compare on the entry read in the cycle before
   assign hit = cmp_live_ff && held_ff[cmp_idx_ff] &&
                (rd_entry.device == dev_ff) && (rd_entry.inode == ino_ff);
   assign free_here = cmp_live_ff && !held_ff[cmp_idx_ff] && !free_found_ff;
   assign claim_idx = free_found_ff ? free_idx_ff : cmp_idx_ff;

   ric_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (NUM_SLOTS)
   ) u_entry_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_raw)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_ff       <= '0;
         issue_live_ff <= 1'b0;
         cmp_live_ff   <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         issue_live_ff <= issue_live_in;
         cmp_live_ff   <= cmp_live_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      free_idx_ff  <= free_idx_in;
      op_ff        <= op_in;
      dev_ff       <= dev_in;
      ino_ff       <= ino_in;
      slot_ff      <= slot_in_q;
      rsp_data_ff  <= rsp_data_in;
   end

   // Sequencer: next state, table updates and result
   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      issue_idx_in  = issue_idx_ff;
      issue_live_in = issue_live_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_live_in   = cmp_live_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      op_in         = op_ff;
      dev_in        = dev_ff;
      ino_in        = ino_ff;
      slot_in_q     = slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cmp_idx_ff;
      ram_wr_data   = rd_entry;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = issue_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Capture the request and read the addressed slot
            if (req_fire) begin
               op_in         = req_code_type'(req_tuser);
               dev_in        = req_tdata.device_id;
               ino_in        = req_tdata.inode_number;
               slot_in_q     = req_tdata.slot_in;
               issue_idx_in  = '0;
               issue_live_in = 1'b1;
               cmp_live_in   = 1'b0;
               free_found_in = 1'b0;
               ram_rd_en     = 1'b1;
               ram_rd_addr   = SLOT_W'(req_tdata.slot_in);
               if (req_code_type'(req_tuser) == REQ_ACQUIRE) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_SLOT;
               end
            end
         end

         S_SCAN: begin
            // Issue the next slot read
            ram_rd_en     = issue_live_ff;
            ram_rd_addr   = issue_idx_ff;
            cmp_live_in   = issue_live_ff;
            cmp_idx_in    = issue_idx_ff;
            issue_idx_in  = issue_idx_ff + SLOT_W'(1);
            issue_live_in = issue_live_ff && (issue_idx_ff != LAST_SLOT);

            // Remember the lowest free slot
            if (free_here) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end

            rsp_data_in.pad             = '0;
            rsp_data_in.load_needed     = 1'b0;
            rsp_data_in.needs_writeback = 1'b0;

            priority if (hit) begin
               // Key found: bump the count unless saturated
               rsp_data_in.slot_out = 6'(cmp_idx_ff);
               if (rd_entry.refs == '1) begin
                  rsp_data_in.status  = ST_OVF;
                  rsp_data_in.ref_now = 16'(rd_entry.refs);
               end else begin
                  ram_wr_en            = 1'b1;
                  ram_wr_addr          = cmp_idx_ff;
                  ram_wr_data          = rd_entry;
                  ram_wr_data.refs     = rd_entry.refs + REF_BITS'(1);
                  rsp_data_in.status   = ST_OK;
                  rsp_data_in.ref_now  = 16'(rd_entry.refs + REF_BITS'(1));
               end
               issue_live_in = 1'b0;
               cmp_live_in   = 1'b0;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (cmp_live_ff && (cmp_idx_ff == LAST_SLOT)) begin
               // Walk done without a match: claim or report full
               if (free_found_ff || free_here) begin
                  ram_wr_en                = 1'b1;
                  ram_wr_addr              = claim_idx;
                  ram_wr_data.refs         = REF_BITS'(1);
                  ram_wr_data.device       = dev_ff;
                  ram_wr_data.inode        = ino_ff;
                  ram_wr_data.dirty        = 1'b0;
                  held_in[claim_idx]       = 1'b1;
                  rsp_data_in.slot_out     = 6'(claim_idx);
                  rsp_data_in.status       = ST_OK;
                  rsp_data_in.load_needed  = 1'b1;
                  rsp_data_in.ref_now      = 16'd1;
               end else begin
                  rsp_data_in.slot_out     = '0;
                  rsp_data_in.status       = ST_FULL;
                  rsp_data_in.ref_now      = '0;
               end
               issue_live_in = 1'b0;
               cmp_live_in   = 1'b0;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else begin
               // Keep walking
               state_in = S_SCAN;
            end
         end

         S_SLOT: begin
            rsp_data_in.pad             = '0;
            rsp_data_in.slot_out        = slot_ff;
            rsp_data_in.status          = ST_OK;
            rsp_data_in.load_needed     = 1'b0;
            rsp_data_in.needs_writeback = 1'b0;
            rsp_data_in.ref_now         = '0;
            ram_wr_addr                 = slot_idx;

            unique case (op_ff)
               REQ_RELEASE: begin
                  // Drop one reference, free the slot at zero
                  if (!slot_held) begin
                     rsp_data_in.status = ST_FREE_REL;
                  end else begin
                     ram_wr_en           = 1'b1;
                     rsp_data_in.ref_now = 16'(dec_refs);
                     if (dec_refs == '0) begin
                        ram_wr_data                 = '0;
                        held_in[slot_idx]           = 1'b0;
                        rsp_data_in.needs_writeback = rd_entry.dirty;
                     end else begin
                        ram_wr_data.refs = dec_refs;
                     end
                  end
               end
               REQ_MARK: begin
                  // Set dirty on a held slot
                  if (slot_held) begin
                     ram_wr_en           = 1'b1;
                     ram_wr_data.dirty   = 1'b1;
                     rsp_data_in.ref_now = 16'(rd_entry.refs);
                  end
               end
               REQ_ACQUIRE, REQ_NONE: begin
                  // Unused code: all-zero result
                  rsp_data_in.slot_out = '0;
               end
            endcase
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Checks
   a_cmp_follows_issue: assert property (@(posedge clock) disable iff (reset)
      cmp_live_ff |-> $past(issue_live_ff))
      else $error("compare stage live without a read issued");

   a_claim_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.load_needed) |->
      (rsp_data_ff.status == ST_OK && rsp_data_ff.ref_now == 16'd1))
      else $error("claimed slot result inconsistent");

   a_full_only_when_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == ST_FULL) |-> (&held_ff))
      else $error("table full reported with a free slot");

   a_one_held_change: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(held_ff ^ $past(held_ff)) <= 1))
      else $error("more than one slot changed held state");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request accepted while busy");

endmodule

`default_nettype wire

// File: rtl/ric_ram.sv
// ----------------------------------------------------------------------------
// ric_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ric_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                            rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: bench/tb_refcounted_inode_cache_table.sv
// ----------------------------------------------------------------------------
// tb_refcounted_inode_cache_table: self-checking bench for the inode slot table
// Streams acquire, release and mark requests into the table, predicts every
// response from a software copy of the slot table, and compares each field
// of each response as it leaves the block. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_refcounted_inode_cache_table;
   import ric_pkg::*;

   localparam int          DIRECTED_ITEMS = 22;
   localparam int          RANDOM_ITEMS   = 1800;
   localparam int          POOL_MAX       = NUM_SLOTS + 16;
   localparam int unsigned CYCLE_LIMIT    = 2_000_000;

   localparam logic [REF_BITS-1:0] REF_MAX = '1;

   // One queued request: the code on tuser and the payload on tdata
   typedef struct packed {
      req_code_type code;
      req_data_type data;
   } request_item_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   req_data_type req_tdata  = '0;
   logic [1:0]   req_tuser  = REQ_NONE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   rsp_data_type rsp_tdata;

   // Requests waiting to be sent, responses waiting to arrive
   request_item_type req_backlog[$];
   rsp_data_type     rsp_due[$];

   // Shadow copy of the slot table
   logic [REF_BITS-1:0] slot_refs  [NUM_SLOTS];
   logic [7:0]          slot_dev   [NUM_SLOTS];
   logic [31:0]         slot_ino   [NUM_SLOTS];
   logic                slot_dirty [NUM_SLOTS];

   // Key pool of the current random round
   logic [7:0]  pool_dev [POOL_MAX];
   logic [31:0] pool_ino [POOL_MAX];

   int unsigned queued_count   = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_gap       = 0;
   int unsigned ready_left     = 0;
   logic        calm           = 1'b0;

   refcounted_inode_cache_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle length: mostly none or short, now and then long; none while calm
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Apply one request to the shadow table and return the response it earns
   function automatic rsp_data_type predict_table_response(request_item_type it);
      rsp_data_type r;
      int           hit;
      int           vacant;
      int           s;
      r      = '0;
      r.status = ST_OK;
      hit    = -1;
      vacant = -1;
      s      = int'(it.data.slot_in);
      case (it.code)
         REQ_ACQUIRE: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (slot_refs[i] != '0) begin
                  if (hit < 0 && slot_dev[i] == it.data.device_id &&
                      slot_ino[i] == it.data.inode_number)
                     hit = i;
               end else if (vacant < 0) begin
                  vacant = i;
               end
            end
            if (hit >= 0) begin
               // refuse to wrap a saturated count
               r.slot_out = 6'(hit);
               if (slot_refs[hit] == REF_MAX) begin
                  r.status = ST_OVF;
               end else begin
                  slot_refs[hit] = slot_refs[hit] + 1'b1;
               end
               r.ref_now = 16'(slot_refs[hit]);
            end else if (vacant < 0) begin
               r.status = ST_FULL;
            end else begin
               slot_refs[vacant]  = REF_BITS'(1);
               slot_dev[vacant]   = it.data.device_id;
               slot_ino[vacant]   = it.data.inode_number;
               slot_dirty[vacant] = 1'b0;
               r.slot_out    = 6'(vacant);
               r.load_needed = 1'b1;
               r.ref_now     = 16'd1;
            end
         end
         REQ_RELEASE: begin
            r.slot_out = it.data.slot_in;
            if (s >= NUM_SLOTS || slot_refs[s] == '0) begin
               r.status = ST_FREE_REL;
            end else begin
               slot_refs[s] = slot_refs[s] - 1'b1;
               // free the slot on the last reference
               if (slot_refs[s] == '0) begin
                  r.needs_writeback = slot_dirty[s];
                  slot_dirty[s] = 1'b0;
                  slot_dev[s]   = '0;
                  slot_ino[s]   = '0;
               end
               r.ref_now = 16'(slot_refs[s]);
            end
         end
         REQ_MARK: begin
            r.slot_out = it.data.slot_in;
            if (s < NUM_SLOTS && slot_refs[s] != '0) begin
               slot_dirty[s] = 1'b1;
               r.ref_now = 16'(slot_refs[s]);
            end
         end
         default: begin
            r = '0;
         end
      endcase
      return r;
   endfunction

   task automatic queue_request(req_code_type code, logic [7:0] dev, logic [31:0] ino,
                                logic [5:0] slot);
      request_item_type it;
      it                   = '0;
      it.code              = code;
      it.data.device_id    = dev;
      it.data.inode_number = ino;
      it.data.slot_in      = slot;
      req_backlog.push_back(it);
      queued_count++;
   endtask

   // Hold until every queued request is sent and every response is back
   task automatic wait_for_quiet();
      while (req_backlog.size() != 0 || rsp_due.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endtask

   // Driver: present the backlog front, hold it until taken, then idle a while
   always @(posedge clock) begin : driver
      request_item_type sent;
      int unsigned      gap_now;
      logic             taken;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= REQ_NONE;
         send_gap   <= 0;
      end else begin
         taken   = req_tvalid && req_tready;
         gap_now = send_gap;
         if (taken) begin
            sent = req_backlog.pop_front();
            rsp_due.push_back(predict_table_response(sent));
            gap_now = pick_gap();
         end
         if (req_tvalid && !taken) begin
            // hold the pending transaction
         end else if (gap_now != 0) begin
            req_tvalid <= 1'b0;
            gap_now = gap_now - 1;
         end else if (req_backlog.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= req_backlog[0].data;
            req_tuser  <= req_backlog[0].code;
         end else begin
            req_tvalid <= 1'b0;
         end
         send_gap <= gap_now;
      end
   end

   // Monitor: compare each response transaction, then toggle ready at random
   always @(posedge clock) begin : monitor
      rsp_data_type due;
      int unsigned  g;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response with nothing pending: 0x%0h", rsp_tdata);
            end else begin
               due = rsp_due.pop_front();
               check_field("slot_out", 32'(due.slot_out), 32'(rsp_tdata.slot_out));
               check_field("status", 32'(due.status), 32'(rsp_tdata.status));
               check_field("load_needed", 32'(due.load_needed),
                           32'(rsp_tdata.load_needed));
               check_field("needs_writeback", 32'(due.needs_writeback),
                           32'(rsp_tdata.needs_writeback));
               check_field("ref_now", 32'(due.ref_now), 32'(rsp_tdata.ref_now));
               check_field("pad", 32'(due.pad), 32'(rsp_tdata.pad));
            end
         end
         if (ready_left != 0) begin
            ready_left <= ready_left - 1;
         end else begin
            g = pick_gap();
            rsp_tready <= (g == 0);
            ready_left <= (g == 0) ? $urandom_range(0, 5) : g - 1;
         end
      end
   end

   // Count cycles, switch calm stretches, and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 1024 == 1023) calm <= ($urandom_range(0, 3) == 0);
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned pool_size;
      int unsigned round_len;
      int unsigned pick;
      int unsigned span;
      int unsigned k;
      logic        first_round;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_refs[i]  = '0;
         slot_dev[i]   = '0;
         slot_ino[i]   = '0;
         slot_dirty[i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: free-slot cases, key extremes, hits, dirty write-back, reuse
      queue_request(REQ_MARK,    8'h00, 32'h0000_0000, 6'd0);
      queue_request(REQ_RELEASE, 8'h00, 32'h0000_0000, 6'd63);
      queue_request(REQ_NONE,    8'hFF, 32'hFFFF_FFFF, 6'd63);
      queue_request(REQ_ACQUIRE, 8'h00, 32'h0000_0000, 6'd63);
      queue_request(REQ_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 6'd0);
      queue_request(REQ_ACQUIRE, 8'h00, 32'h0000_0000, 6'd0);
      queue_request(REQ_ACQUIRE, 8'h00, 32'h0000_0001, 6'd0);
      queue_request(REQ_ACQUIRE, 8'h01, 32'h0000_0000, 6'd0);
      queue_request(REQ_ACQUIRE, 8'hFF, 32'hFFFF_FFFF, 6'd0);
      queue_request(REQ_MARK,    8'hFF, 32'hFFFF_FFFF, 6'd1);
      queue_request(REQ_RELEASE, 8'h00, 32'h0000_0000, 6'd1);
      queue_request(REQ_RELEASE, 8'h00, 32'h0000_0000, 6'd1);
      queue_request(REQ_ACQUIRE, 8'hA5, 32'h5A5A_5A5A, 6'd21);
      queue_request(REQ_RELEASE, 8'h5A, 32'hA5A5_A5A5, 6'd1);
      queue_request(REQ_RELEASE, 8'h00, 32'h0000_0000, 6'd1);
      queue_request(REQ_MARK,    8'h00, 32'h0000_0000, 6'd1);
      queue_request(REQ_MARK,    8'h00, 32'h0000_0000, 6'd0);
      queue_request(REQ_RELEASE, 8'h00, 32'h0000_0000, 6'd0);
      queue_request(REQ_RELEASE, 8'h00, 32'h0000_0000, 6'd0);
      queue_request(REQ_RELEASE, 8'h00, 32'h0000_0000, 6'd0);
      queue_request(REQ_NONE,    8'h00, 32'h0000_0000, 6'd0);
      queue_request(REQ_ACQUIRE, 8'h00, 32'h0000_0000, 6'd42);
      wait_for_quiet();

      // Random rounds over small key pools; large pools drive the table full
      first_round = 1'b1;
      while (queued_count < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (first_round) pool_size = NUM_SLOTS + 8;
         else if (pick < 2) pool_size = $urandom_range(NUM_SLOTS - 4, POOL_MAX);
         else if (pick < 5) pool_size = $urandom_range(9, 40);
         else pool_size = $urandom_range(1, 8);
         first_round = 1'b0;

         // share devices and small inode numbers so keys differ in one part
         for (int i = 0; i < pool_size; i++) begin
            pool_dev[i] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 1));
            pool_ino[i] = $urandom_range(0, 1) ? 32'($urandom)
                                               : 32'($urandom_range(0, 3));
         end
         if (pool_size >= NUM_SLOTS - 4)
            for (int i = 0; i < pool_size; i++)
               queue_request(REQ_ACQUIRE, pool_dev[i], pool_ino[i], 6'($urandom));

         span = (pool_size + 3 < NUM_SLOTS) ? pool_size + 3 : NUM_SLOTS - 1;
         round_len = $urandom_range(20, 100);
         for (int n = 0; n < round_len; n++) begin
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, pool_size - 1);
            if (pick < 45)
               queue_request(REQ_ACQUIRE, pool_dev[k], pool_ino[k], 6'($urandom));
            else if (pick < 48)
               queue_request(REQ_ACQUIRE, 8'($urandom), 32'($urandom), 6'($urandom));
            else if (pick < 83)
               queue_request(REQ_RELEASE, 8'($urandom), 32'($urandom),
                             6'($urandom_range(0, span)));
            else if (pick < 95)
               queue_request(REQ_MARK, 8'($urandom), 32'($urandom),
                             6'($urandom_range(0, span)));
            else if (pick < 98)
               queue_request(REQ_NONE, 8'($urandom), 32'($urandom), 6'($urandom));
            else
               queue_request($urandom_range(0, 1) ? REQ_RELEASE : REQ_MARK,
                             8'($urandom), 32'($urandom), 6'($urandom));
         end

         // sweep the table down so later small pools find free slots
         if (pool_size >= NUM_SLOTS - 4 || $urandom_range(0, 4) == 0) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if ($urandom_range(0, 1))
                  queue_request(REQ_MARK, 8'($urandom), 32'($urandom), 6'(s));
               repeat ($urandom_range(1, 3))
                  queue_request(REQ_RELEASE, 8'($urandom), 32'($urandom), 6'(s));
            end
         end

         if ($urandom_range(0, 3) == 0) wait_for_quiet();
      end

      wait_for_quiet();
      repeat (NUM_SLOTS + 16) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
rtl/ric_pkg.sv
rtl/ric_ram.sv
rtl/refcounted_inode_cache_table.sv
bench/tb_refcounted_inode_cache_table.sv
